### src/stt_pkg.sv
// Shared types and codes for the source text tokenizer.
package stt_pkg;

    localparam int LINE_BITS = 16;
    localparam int OFF_BITS  = 24;
    localparam int LEN_BITS  = 16;
    localparam int KW_CHARS  = 6;

    // Scanner modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_IDENT   = 4'd2;
    localparam logic [3:0] M_INT     = 4'd3;
    localparam logic [3:0] M_DOT     = 4'd4;
    localparam logic [3:0] M_FRAC    = 4'd5;
    localparam logic [3:0] M_STRING  = 4'd6;
    localparam logic [3:0] M_OPER    = 4'd7;
    localparam logic [3:0] M_DONE    = 4'd8;

    // Token kinds
    localparam logic [5:0] K_F        = 6'd0;
    localparam logic [5:0] K_RETURN   = 6'd1;
    localparam logic [5:0] K_IF       = 6'd2;
    localparam logic [5:0] K_ELSIF    = 6'd3;
    localparam logic [5:0] K_ELSE     = 6'd4;
    localparam logic [5:0] K_U8       = 6'd9;
    localparam logic [5:0] K_U16      = 6'd10;
    localparam logic [5:0] K_U32      = 6'd11;
    localparam logic [5:0] K_U64      = 6'd12;
    localparam logic [5:0] K_I8       = 6'd13;
    localparam logic [5:0] K_I16      = 6'd14;
    localparam logic [5:0] K_I32      = 6'd15;
    localparam logic [5:0] K_I64      = 6'd16;
    localparam logic [5:0] K_F32      = 6'd17;
    localparam logic [5:0] K_F64      = 6'd18;
    localparam logic [5:0] K_STR      = 6'd19;
    localparam logic [5:0] K_BOOL     = 6'd20;
    localparam logic [5:0] K_NULL     = 6'd21;
    localparam logic [5:0] K_ERROR    = 6'd22;
    localparam logic [5:0] K_PLUS     = 6'd23;
    localparam logic [5:0] K_MINUS    = 6'd24;
    localparam logic [5:0] K_STAR     = 6'd25;
    localparam logic [5:0] K_SLASH    = 6'd26;
    localparam logic [5:0] K_PERCENT  = 6'd27;
    localparam logic [5:0] K_INC      = 6'd28;
    localparam logic [5:0] K_GT       = 6'd30;
    localparam logic [5:0] K_GE       = 6'd31;
    localparam logic [5:0] K_LT       = 6'd32;
    localparam logic [5:0] K_LE       = 6'd33;
    localparam logic [5:0] K_IDENT    = 6'd34;
    localparam logic [5:0] K_NUMBER   = 6'd35;
    localparam logic [5:0] K_STRING   = 6'd36;
    localparam logic [5:0] K_COLON    = 6'd37;
    localparam logic [5:0] K_ARROW    = 6'd38;
    localparam logic [5:0] K_ASSIGN   = 6'd39;
    localparam logic [5:0] K_END      = 6'd40;
    localparam logic [5:0] K_LPAREN   = 6'd41;
    localparam logic [5:0] K_RPAREN   = 6'd42;
    localparam logic [5:0] K_LBRACE   = 6'd43;
    localparam logic [5:0] K_RBRACE   = 6'd44;
    localparam logic [5:0] K_COMMA    = 6'd45;
    localparam logic [5:0] K_DOTK     = 6'd46;

    typedef struct packed {
        logic [3:0]           mode;
        logic [LEN_BITS-1:0]  len;
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] col;
        logic [OFF_BITS-1:0]  off;
        logic [OFF_BITS-1:0]  start;
        logic [7:0]           pop;
    } scan_st_t;

    typedef struct packed {
        logic [5:0]           kind;
        logic [LINE_BITS-1:0] line;
        logic [LINE_BITS-1:0] col;
        logic [OFF_BITS-1:0]  offset;
        logic [LEN_BITS-1:0]  length;
    } tok_t;

    // Up to three tokens come out of one beat
    typedef struct packed {
        tok_t [2:0] tok;
        logic [1:0] count;
    } bundle_t;

endpackage

### src/stt_scan.sv
// Next-state and token logic of the scanner for one input beat.
module stt_scan (
    input  stt_pkg::scan_st_t st,
    input  logic [7:0]        kw [stt_pkg::KW_CHARS],
    input  logic [7:0]        char_byte,
    input  logic              end_of_text,
    output stt_pkg::scan_st_t st_next,
    output logic [7:0]        kw_next [stt_pkg::KW_CHARS],
    output stt_pkg::bundle_t  bundle
);

    typedef struct packed {
        stt_pkg::scan_st_t s;
        logic              emit;
        logic [5:0]        kind;
        logic              kw0;
    } idle_res_t;

    function automatic stt_pkg::scan_st_t bump(stt_pkg::scan_st_t s);
        stt_pkg::scan_st_t r;
        r = s;
        if (r.off != '1) r.off = r.off + 1'b1;
        if (r.col != '1) r.col = r.col + 1'b1;
        return r;
    endfunction

    function automatic stt_pkg::scan_st_t grow(stt_pkg::scan_st_t s);
        stt_pkg::scan_st_t r;
        r = s;
        if (r.len != '1) r.len = r.len + 1'b1;
        return r;
    endfunction

    function automatic stt_pkg::scan_st_t newl(stt_pkg::scan_st_t s);
        stt_pkg::scan_st_t r;
        r = s;
        if (r.line != '1) r.line = r.line + 1'b1;
        r.col = stt_pkg::LINE_BITS'(1);
        return r;
    endfunction

    function automatic stt_pkg::tok_t mk(stt_pkg::scan_st_t s, logic [5:0] k);
        stt_pkg::tok_t t;
        t.kind   = k;
        t.line   = s.line;
        t.col    = (s.col >= s.len) ? s.col - s.len : '0;
        t.offset = s.start;
        t.length = s.len;
        return t;
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] op_kind(logic [7:0] op, logic paired);
        logic [5:0] k;
        case (op)
            "-":     k = paired ? stt_pkg::K_ARROW : stt_pkg::K_MINUS;
            "+":     k = paired ? stt_pkg::K_INC : stt_pkg::K_PLUS;
            "=":     k = stt_pkg::K_ASSIGN;
            ">":     k = paired ? stt_pkg::K_GE : stt_pkg::K_GT;
            default: k = paired ? stt_pkg::K_LE : stt_pkg::K_LT;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] op_second(logic [7:0] op);
        logic [7:0] c;
        case (op)
            "-":     c = ">";
            "+":     c = "+";
            default: c = "=";
        endcase
        return c;
    endfunction

    // Byte at the start of a token, or between tokens
    function automatic idle_res_t idle(stt_pkg::scan_st_t s, logic [7:0] c);
        idle_res_t r;
        r.s    = s;
        r.s.mode = stt_pkg::M_IDLE;
        r.emit = 1'b0;
        r.kind = stt_pkg::K_END;
        r.kw0  = 1'b0;
        if (c == " " || c == 8'h0D || c == 8'h09) begin
            r.s = bump(r.s);
        end else if (c == 8'h0A) begin
            r.s = bump(newl(r.s));
        end else if (c == "#") begin
            r.s = bump(r.s);
            r.s.mode = stt_pkg::M_COMMENT;
        end else begin
            r.s.start = r.s.off;
            r.s.len = '0;
            r.s = grow(bump(r.s));
            if (is_letter(c)) begin
                r.kw0 = 1'b1;
                r.s.mode = stt_pkg::M_IDENT;
            end else if (is_numeral(c)) begin
                r.s.mode = stt_pkg::M_INT;
            end else begin
                case (c)
                    "(": begin r.emit = 1'b1; r.kind = stt_pkg::K_LPAREN; end
                    ")": begin r.emit = 1'b1; r.kind = stt_pkg::K_RPAREN; end
                    "{": begin r.emit = 1'b1; r.kind = stt_pkg::K_LBRACE; end
                    "}": begin r.emit = 1'b1; r.kind = stt_pkg::K_RBRACE; end
                    ":": begin r.emit = 1'b1; r.kind = stt_pkg::K_COLON; end
                    ",": begin r.emit = 1'b1; r.kind = stt_pkg::K_COMMA; end
                    ".": begin r.emit = 1'b1; r.kind = stt_pkg::K_DOTK; end
                    "*": begin r.emit = 1'b1; r.kind = stt_pkg::K_STAR; end
                    "/": begin r.emit = 1'b1; r.kind = stt_pkg::K_SLASH; end
                    "%": begin r.emit = 1'b1; r.kind = stt_pkg::K_PERCENT; end
                    "-", "+", "=", ">", "<":
                    begin
                        r.s.pop = c;
                        r.s.mode = stt_pkg::M_OPER;
                    end
                    "\"": r.s.mode = stt_pkg::M_STRING;
                    default:
                    begin
                        r.emit = 1'b1;
                        r.kind = stt_pkg::K_END;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Match the buffered identifier against the key and type words
    function automatic logic [5:0] word_kind(logic [47:0] w, logic [stt_pkg::LEN_BITS-1:0] n);
        logic [5:0] k;
        k = stt_pkg::K_IDENT;
        case (n)
            16'd1: if (w[47:40] == "f") k = stt_pkg::K_F;
            16'd2:
            begin
                if (w[47:32] == "if") k = stt_pkg::K_IF;
                if (w[47:32] == "i8") k = stt_pkg::K_I8;
                if (w[47:32] == "u8") k = stt_pkg::K_U8;
            end
            16'd3:
            begin
                if (w[47:24] == "int") k = stt_pkg::K_I32;
                if (w[47:24] == "i16") k = stt_pkg::K_I16;
                if (w[47:24] == "i32") k = stt_pkg::K_I32;
                if (w[47:24] == "i64") k = stt_pkg::K_I64;
                if (w[47:24] == "u16") k = stt_pkg::K_U16;
                if (w[47:24] == "u32") k = stt_pkg::K_U32;
                if (w[47:24] == "u64") k = stt_pkg::K_U64;
                if (w[47:24] == "f32") k = stt_pkg::K_F32;
                if (w[47:24] == "f64") k = stt_pkg::K_F64;
                if (w[47:24] == "str") k = stt_pkg::K_STR;
            end
            16'd4:
            begin
                if (w[47:16] == "else") k = stt_pkg::K_ELSE;
                if (w[47:16] == "bool") k = stt_pkg::K_BOOL;
                if (w[47:16] == "null") k = stt_pkg::K_NULL;
            end
            16'd5:
            begin
                if (w[47:8] == "elsif") k = stt_pkg::K_ELSIF;
                if (w[47:8] == "error") k = stt_pkg::K_ERROR;
            end
            16'd6: if (w == "return") k = stt_pkg::K_RETURN;
            default: k = stt_pkg::K_IDENT;
        endcase
        return k;
    endfunction

    always_comb
    begin : step
        stt_pkg::scan_st_t s;
        stt_pkg::tok_t     tk [3];
        logic [1:0]        n;
        idle_res_t         r;
        logic [47:0]       w;
        logic [7:0]        c;
        logic              run_idle;

        s = st;
        n = '0;
        c = char_byte;
        run_idle = 1'b0;
        for (int i = 0; i < 3; i++) tk[i] = '0;
        for (int i = 0; i < stt_pkg::KW_CHARS; i++) kw_next[i] = kw[i];
        w = {kw[0], kw[1], kw[2], kw[3], kw[4], kw[5]};
        r = idle(s, c);

        if (end_of_text) begin
            // Flush the open token, then the end token
            case (s.mode)
                stt_pkg::M_IDENT:
                begin
                    tk[n] = mk(s, word_kind(w, s.len)); n = n + 1'b1;
                end
                stt_pkg::M_INT, stt_pkg::M_FRAC:
                begin
                    tk[n] = mk(s, stt_pkg::K_NUMBER); n = n + 1'b1;
                end
                stt_pkg::M_DOT:
                begin
                    tk[n] = mk(s, stt_pkg::K_NUMBER); n = n + 1'b1;
                    r = idle(s, ".");
                    s = r.s;
                    tk[n] = mk(s, r.kind); n = n + 1'b1;
                end
                stt_pkg::M_STRING:
                begin
                    tk[n] = mk(s, stt_pkg::K_END); n = n + 1'b1;
                end
                stt_pkg::M_OPER:
                begin
                    tk[n] = mk(s, op_kind(s.pop, 1'b0)); n = n + 1'b1;
                end
                default: ;
            endcase
            s.start = s.off;
            s.len = '0;
            tk[n] = mk(s, stt_pkg::K_END); n = n + 1'b1;
            s.mode = stt_pkg::M_DONE;
        end else begin
            case (s.mode)
                stt_pkg::M_COMMENT:
                begin
                    if (c == 8'h0A) run_idle = 1'b1;
                    else s = bump(s);
                end
                stt_pkg::M_IDENT:
                begin
                    if (is_letter(c) || is_numeral(c)) begin
                        if (s.len < stt_pkg::LEN_BITS'(stt_pkg::KW_CHARS))
                            kw_next[s.len[2:0]] = c;
                        s = grow(bump(s));
                    end else begin
                        tk[n] = mk(s, word_kind(w, s.len)); n = n + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                stt_pkg::M_INT:
                begin
                    if (is_numeral(c)) s = grow(bump(s));
                    else if (c == ".") s.mode = stt_pkg::M_DOT;
                    else begin
                        tk[n] = mk(s, stt_pkg::K_NUMBER); n = n + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                stt_pkg::M_DOT:
                begin
                    if (is_numeral(c)) begin
                        s = grow(bump(grow(bump(s))));
                        s.mode = stt_pkg::M_FRAC;
                    end else begin
                        // Number, then the held dot, then this byte
                        tk[n] = mk(s, stt_pkg::K_NUMBER); n = n + 1'b1;
                        r = idle(s, ".");
                        s = r.s;
                        tk[n] = mk(s, r.kind); n = n + 1'b1;
                        r = idle(s, c);
                        run_idle = 1'b1;
                    end
                end
                stt_pkg::M_FRAC:
                begin
                    if (is_numeral(c)) s = grow(bump(s));
                    else begin
                        tk[n] = mk(s, stt_pkg::K_NUMBER); n = n + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                stt_pkg::M_STRING:
                begin
                    if (c == 8'h0A) s = newl(s);
                    s = grow(bump(s));
                    if (c == "\"") begin
                        tk[n] = mk(s, stt_pkg::K_STRING); n = n + 1'b1;
                        s.mode = stt_pkg::M_IDLE;
                    end
                end
                stt_pkg::M_OPER:
                begin
                    if (c == op_second(s.pop)) begin
                        s = grow(bump(s));
                        tk[n] = mk(s, op_kind(s.pop, 1'b1)); n = n + 1'b1;
                        s.mode = stt_pkg::M_IDLE;
                    end else begin
                        tk[n] = mk(s, op_kind(s.pop, 1'b0)); n = n + 1'b1;
                        run_idle = 1'b1;
                    end
                end
                stt_pkg::M_DONE: ;
                default: run_idle = 1'b1;
            endcase
            // Start the next token from this byte
            if (run_idle) begin
                if (s.mode != stt_pkg::M_DOT) r = idle(s, c);
                s = r.s;
                if (r.kw0) kw_next[0] = c;
                if (r.emit) begin
                    tk[n] = mk(s, r.kind); n = n + 1'b1;
                end
            end
        end

        st_next = s;
        bundle.count = n;
        for (int i = 0; i < 3; i++) bundle.tok[i] = tk[i];
    end

endmodule

### src/source_text_tokenizer_unit.sv
// The first token of a byte shows on the outputs in the cycle after the byte's beat is taken.
// The unit takes one byte per cycle while each byte yields at most one token and out_ready
// is high; a byte that yields k tokens (k up to 3) holds the input until its last token is
// taken, one token per cycle from the result register while out_ready is high.
// Reset clears the scanner to line 1, column 1, offset 0 and empties the result register.
module source_text_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic [23:0] token_offset,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    stt_pkg::scan_st_t st_reg;
    stt_pkg::scan_st_t st_next;
    logic [7:0]        kw_reg  [stt_pkg::KW_CHARS];
    logic [7:0]        kw_next [stt_pkg::KW_CHARS];
    stt_pkg::bundle_t  bun_reg;
    stt_pkg::bundle_t  bun_next;
    logic [1:0]        idx_reg;
    logic              in_acc;
    logic              out_acc;
    logic              last_tok;
    stt_pkg::tok_t     cur;

    stt_scan u_scan (
        .st          (st_reg),
        .kw          (kw_reg),
        .char_byte   (char_byte),
        .end_of_text (end_of_text),
        .st_next     (st_next),
        .kw_next     (kw_next),
        .bundle      (bun_next)
    );

    // Handshake: take a new beat when no token is pending or as the last pending token leaves
    assign last_tok  = (idx_reg == bun_reg.count - 2'd1);
    assign out_valid = (bun_reg.count != 2'd0);
    assign out_acc   = out_valid && out_ready;
    assign in_ready  = !out_valid || (out_ready && last_tok);
    assign in_acc    = in_valid && in_ready;

    // Drive the current token
    assign cur          = bun_reg.tok[idx_reg];
    assign token_kind   = cur.kind;
    assign token_line   = cur.line;
    assign token_column = cur.col;
    assign token_offset = cur.offset;
    assign token_length = cur.length;
    assign last_of_run  = last_tok;

    // Advance scanner state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg.mode  <= stt_pkg::M_IDLE;
            st_reg.len   <= '0;
            st_reg.line  <= stt_pkg::LINE_BITS'(1);
            st_reg.col   <= stt_pkg::LINE_BITS'(1);
            st_reg.off   <= '0;
            st_reg.start <= '0;
            st_reg.pop   <= '0;
            bun_reg      <= '0;
            idx_reg      <= '0;
        end else begin
            if (in_acc) begin
                st_reg  <= st_next;
                bun_reg <= bun_next;
                idx_reg <= '0;
            end else if (out_acc) begin
                if (last_tok) bun_reg.count <= '0;
                else idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Hold the word buffer
    always_ff @(posedge clk)
    begin
        if (in_acc) begin
            for (int i = 0; i < stt_pkg::KW_CHARS; i++) kw_reg[i] <= kw_next[i];
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> idx_reg < bun_reg.count)
        else $error("token index past bundle");

    a_end_gives_token: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && end_of_text |=> out_valid)
        else $error("end mark gave no token");

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode == stt_pkg::M_DONE |=> st_reg.mode == stt_pkg::M_DONE)
        else $error("scanner left done mode");
`endif

endmodule
